[hdl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TLNF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlnf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TLNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlnf assertion failed");

`endif

[hdl/tlnf_pkg.sv]
// Package: constants, types and codes of the line-numbering text filter
`timescale 1ns / 1ps
package tlnf_pkg;

	localparam int COUNT_DIGITS = 10;
	localparam int PAD_WIDTH    = 6;
	localparam int COUNT_W      = 4 * COUNT_DIGITS;
	localparam int IDX_W        = $clog2((COUNT_DIGITS > PAD_WIDTH) ? COUNT_DIGITS : PAD_WIDTH);
	localparam int CFG_IDX_W    = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_NL       = 8'd10;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_DOLLAR   = 8'd36;
	localparam logic [7:0] CH_ZERO     = 8'd48;
	localparam logic [7:0] CH_I        = 8'd73;
	localparam logic [7:0] CH_CARET    = 8'd94;
	localparam logic [7:0] CTRL_LIMIT  = 8'd32;
	localparam logic [7:0] CTRL_OFFSET = 8'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUMBER_ALL      = 3'd0,
		REG_NUMBER_NONEMPTY = 3'd1,
		REG_FOLD_EMPTY      = 3'd2,
		REG_MARK_TABS       = 3'd3,
		REG_MARK_ENDS       = 3'd4,
		REG_SHOW_CONTROL    = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_DIGIT,
		PH_TAB,
		PH_BODY0,
		PH_BODY1
	} phase_t;

	typedef struct packed {
		logic number_all;
		logic number_nonempty;
		logic fold_empty;
		logic mark_tabs;
		logic mark_ends;
		logic show_control;
	} tlnf_cfg_t;

	// one classified item as passed from front to back
	typedef struct packed {
		phase_t             start_phase;
		logic [IDX_W-1:0]   start_idx;
		logic [IDX_W-1:0]   top;
		logic [COUNT_W-1:0] count;
		logic [7:0]         body0;
		logic [7:0]         body1;
		logic               two;
	} tlnf_cmd_t;

endpackage

[hdl/tlnf_ifs.sv]
// Interfaces: input byte stream, output character stream and configuration write channel
`timescale 1ns / 1ps
interface tlnf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tlnf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tlnf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tlnf_pkg::CFG_IDX_W-1:0] index;
	logic                           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/tlnf_front.sv]
// Front end: accepts bytes, keeps line state and counter, classifies each item
`timescale 1ns / 1ps
module tlnf_front (
	input  logic                clk,
	input  logic                arst_n,
	tlnf_in_if.sink             in_ch,
	tlnf_cfg_if.sink            cfg,
	input  logic                full,
	output logic                push,
	output tlnf_pkg::tlnf_cmd_t cmd
);
	import tlnf_pkg::*;

	tlnf_cfg_t          cfg_q;
	logic [COUNT_W-1:0] count_q;
	logic               at_start_q;
	logic               prev_empty_q;

	logic               accept;
	logic               is_nl;
	logic               is_tab;
	logic               empty;
	logic               drop;
	logic               numbered;
	logic [COUNT_W-1:0] count_inc;
	logic [IDX_W-1:0]   top;
	logic [IDX_W-1:0]   n_spaces;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && !full;

	assign is_nl    = (in_ch.in_byte == CH_NL);
	assign is_tab   = (in_ch.in_byte == CH_TAB);
	assign empty    = at_start_q && is_nl;
	assign drop     = cfg_q.fold_empty && empty && prev_empty_q;
	assign numbered = at_start_q && (cfg_q.number_nonempty ? !empty : cfg_q.number_all);
	assign push     = accept && !drop;

	// most significant nonzero digit
	always_comb begin
		top = '0;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (count_q[4*i +: 4] != 4'd0)
				top = IDX_W'(i);
		end
	end

	always_comb begin
		if (int'(top) + 1 < PAD_WIDTH)
			n_spaces = IDX_W'(PAD_WIDTH - 1 - int'(top));
		else
			n_spaces = '0;
	end

	// BCD increment, held at all nines
	always_comb begin
		logic [3:0] d;
		logic       carry;
		logic       all_nines;
		carry     = 1'b1;
		all_nines = 1'b1;
		count_inc = count_q;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			d = count_q[4*i +: 4];
			if (d != 4'd9)
				all_nines = 1'b0;
			if (carry)
				count_inc[4*i +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
			carry = carry && (d == 4'd9);
		end
		if (all_nines)
			count_inc = count_q;
	end

	always_comb begin
		cmd.count = count_q;
		cmd.top   = top;
		cmd.body0 = in_ch.in_byte;
		cmd.body1 = 8'd0;
		cmd.two   = 1'b0;
		if (cfg_q.mark_tabs && is_tab) begin
			cmd.body0 = CH_CARET;
			cmd.body1 = CH_I;
			cmd.two   = 1'b1;
		end else if (cfg_q.mark_ends && is_nl) begin
			cmd.body0 = CH_DOLLAR;
			cmd.body1 = CH_NL;
			cmd.two   = 1'b1;
		end else if (cfg_q.show_control && in_ch.in_byte < CTRL_LIMIT && !is_nl && !is_tab) begin
			cmd.body0 = CH_CARET;
			cmd.body1 = in_ch.in_byte + CTRL_OFFSET;
			cmd.two   = 1'b1;
		end
		if (!numbered) begin
			cmd.start_phase = PH_BODY0;
			cmd.start_idx   = top;
		end else if (n_spaces != '0) begin
			cmd.start_phase = PH_SPACE;
			cmd.start_idx   = n_spaces - IDX_W'(1);
		end else begin
			cmd.start_phase = PH_DIGIT;
			cmd.start_idx   = top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NUMBER_ALL:      cfg_q.number_all      <= cfg.data;
				REG_NUMBER_NONEMPTY: cfg_q.number_nonempty <= cfg.data;
				REG_FOLD_EMPTY:      cfg_q.fold_empty      <= cfg.data;
				REG_MARK_TABS:       cfg_q.mark_tabs       <= cfg.data;
				REG_MARK_ENDS:       cfg_q.mark_ends       <= cfg.data;
				REG_SHOW_CONTROL:    cfg_q.show_control    <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= COUNT_W'(1);
			at_start_q   <= 1'b1;
			prev_empty_q <= 1'b0;
		end else if (accept) begin
			if (drop) begin
				prev_empty_q <= 1'b1;
			end else begin
				at_start_q   <= is_nl;
				prev_empty_q <= empty;
				if (is_nl && !(cfg_q.number_nonempty && empty))
					count_q <= count_inc;
			end
		end
	end

endmodule

[hdl/tlnf_queue.sv]
// Short command queue between front and back
`timescale 1ns / 1ps
module tlnf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tlnf_pkg::tlnf_cmd_t cmd_in,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output tlnf_pkg::tlnf_cmd_t head
);
	import tlnf_pkg::*;

	tlnf_cmd_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;

	assign full       = (fill_q == QFILL_W'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				fill_q <= fill_q + QFILL_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - QFILL_W'(1);
		end
	end

endmodule

[hdl/tlnf_back.sv]
// Back end: expands each command into prefix and body characters, output register
`timescale 1ns / 1ps
module tlnf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  tlnf_pkg::tlnf_cmd_t head,
	output logic                pop,
	tlnf_out_if.source          out_ch
);
	import tlnf_pkg::*;

	phase_t           phase_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;

	phase_t           cur_phase;
	logic [IDX_W-1:0] cur_idx;
	phase_t           nxt_phase;
	logic [IDX_W-1:0] nxt_idx;
	logic [7:0]       chr;
	logic             last;
	logic             done;
	logic             advance;

	assign cur_phase = busy_q ? phase_q : head.start_phase;
	assign cur_idx   = busy_q ? idx_q : head.start_idx;
	assign advance   = head_valid && (!out_valid_q || out_ch.ready);
	assign pop       = advance && done;

	always_comb begin
		chr       = head.body0;
		last      = 1'b0;
		done      = 1'b0;
		nxt_phase = cur_phase;
		nxt_idx   = cur_idx;
		case (cur_phase)
			PH_SPACE: begin
				chr = CH_SPACE;
				if (cur_idx == '0) begin
					nxt_phase = PH_DIGIT;
					nxt_idx   = head.top;
				end else begin
					nxt_idx = cur_idx - IDX_W'(1);
				end
			end
			PH_DIGIT: begin
				chr = CH_ZERO + {4'd0, head.count[4*cur_idx +: 4]};
				if (cur_idx == '0)
					nxt_phase = PH_TAB;
				else
					nxt_idx = cur_idx - IDX_W'(1);
			end
			PH_TAB: begin
				chr       = CH_TAB;
				nxt_phase = PH_BODY0;
			end
			PH_BODY0: begin
				chr       = head.body0;
				last      = !head.two;
				done      = !head.two;
				nxt_phase = PH_BODY1;
			end
			PH_BODY1: begin
				chr  = head.body1;
				last = 1'b1;
				done = 1'b1;
			end
			default: begin
				last = 1'b1;
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_BODY0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				busy_q      <= !done;
				phase_q     <= nxt_phase;
				idx_q       <= nxt_idx;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= chr;
			last_q     <= last;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.last_of_run = last_q;

endmodule

[hdl/text_line_number_filter.sv]
// Top level of the line-numbering text filter
// An accepted item is first written into the queue; once it is at the head and the output is
// free, the back end loads its first character into the output register. One character per
// cycle while the sink is ready; an item yields 1 to 13 characters (a squeezed blank line none).
// A two-entry queue lets the front accept a new item while the back still expands earlier ones.
// Reset (arst_n low): configuration and output valid cleared, line counter at one, at line start, queue empty.
`timescale 1ns / 1ps
module text_line_number_filter (
	input  logic       clk,
	input  logic       arst_n,
	tlnf_in_if.sink    in_ch,
	tlnf_out_if.source out_ch,
	tlnf_cfg_if.sink   cfg
);
	import tlnf_pkg::*;

	logic      push;
	logic      full;
	logic      pop;
	logic      head_valid;
	tlnf_cmd_t cmd;
	tlnf_cmd_t head;

	tlnf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.cmd    (cmd)
	);

	tlnf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd_in     (cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tlnf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

[hdl/tlnf_checker.sv]
// Port-level checker for the line-numbering text filter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlnf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	`TLNF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`TLNF_ASSERT_NEXT(a_byte_stable, clk, arst_n, out_valid && !out_ready, $stable(out_byte))
	`TLNF_ASSERT_NEXT(a_last_stable, clk, arst_n, out_valid && !out_ready, $stable(last_of_run))
	// an item's characters follow one another without a gap
	`TLNF_ASSERT_NEXT(a_run_continues, clk, arst_n, out_valid && out_ready && !last_of_run, out_valid)
	`TLNF_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind text_line_number_filter tlnf_checker u_tlnf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_byte    (out_ch.out_byte),
	.last_of_run (out_ch.last_of_run),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);

[tb/sv/tb.sv]
// Testbench of the line-numbering text filter: directed table, random phases, numbered tail
`timescale 1ns / 1ps
module tb;
	import tlnf_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 5;
	localparam int IDLE_PCT = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_SHOWN = 10;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 20;
	localparam int N_DIRECTED = 29;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_char_t;

	// one row: a register write, or a byte with an optional typed-in single character
	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic                 val;
		logic [7:0]           b;
		logic                 fixed;
		logic [7:0]           want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlnf_in_if  in_if ();
	tlnf_out_if out_if ();
	tlnf_cfg_if cfg_if ();

	text_line_number_filter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg    (cfg_if)
	);

	// shadow of the filter
	tlnf_cfg_t          cfg_sh;
	logic [COUNT_W-1:0] line_cnt;
	logic               line_start;
	logic               prev_empty;

	out_char_t exp_chars [$];
	int        mismatches = 0;
	int        n_items = 0;
	int        n_chars = 0;
	int        n_writes = 0;
	int        quiet = 0;
	bit        no_idle = 1'b0;

	stim_row_t dir_plan [N_DIRECTED] = '{
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h00, 1'b1, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'hFF, 1'b1, 8'hFF},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h7F, 1'b1, 8'h7F},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h80, 1'b1, 8'h80},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h09, 1'b1, 8'h09},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h01, 1'b1, 8'h01},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b1, 8'h0A},
		'{1'b1, REG_NUMBER_ALL, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_MARK_TABS, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_MARK_ENDS, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_SHOW_CONTROL, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h41, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h09, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h1F, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h7F, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b0, 8'h00},
		'{1'b1, REG_NUMBER_NONEMPTY, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_FOLD_EMPTY, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_SPARE_LO, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_SPARE_HI, 1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h42, 1'b0, 8'h00},
		'{1'b0, REG_NUMBER_ALL, 1'b0, 8'h0A, 1'b0, 8'h00}
	};

	always #HALF_PERIOD clk = ~clk;

	// line counter, saturating at all nines
	function automatic void count_advance();
		logic all9;
		all9 = 1'b1;
		for (int i = 0; i < COUNT_DIGITS; i++)
			if (line_cnt[4*i +: 4] != 4'd9) all9 = 1'b0;
		if (all9) return;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (line_cnt[4*i +: 4] != 4'd9) begin
				line_cnt[4*i +: 4] += 4'd1;
				return;
			end
			line_cnt[4*i +: 4] = 4'd0;
		end
	endfunction

	// characters produced by one text byte; queued only when keep is set
	function automatic void predict_text(input logic [7:0] c, input bit keep);
		out_char_t run [$];
		logic      is_nl;
		logic      empty;
		logic      numbered;
		int        top;
		is_nl = (c == CH_NL);
		empty = line_start && is_nl;
		if (cfg_sh.fold_empty && empty && prev_empty) return;
		if (line_start) begin
			numbered = cfg_sh.number_nonempty ? !empty : cfg_sh.number_all;
			if (numbered) begin
				top = 0;
				for (int i = 0; i < COUNT_DIGITS; i++)
					if (line_cnt[4*i +: 4] != 4'd0) top = i;
				for (int i = top + 1; i < PAD_WIDTH; i++)
					run.push_back('{CH_SPACE, 1'b0});
				for (int i = top; i >= 0; i--)
					run.push_back('{CH_ZERO + 8'(line_cnt[4*i +: 4]), 1'b0});
				run.push_back('{CH_TAB, 1'b0});
			end
			line_start = 1'b0;
		end
		if (cfg_sh.mark_tabs && c == CH_TAB) begin
			run.push_back('{CH_CARET, 1'b0});
			run.push_back('{CH_I, 1'b0});
		end else if (cfg_sh.mark_ends && is_nl) begin
			run.push_back('{CH_DOLLAR, 1'b0});
			run.push_back('{CH_NL, 1'b0});
		end else if (cfg_sh.show_control && c < CTRL_LIMIT && c != CH_NL && c != CH_TAB) begin
			run.push_back('{CH_CARET, 1'b0});
			run.push_back('{c + CTRL_OFFSET, 1'b0});
		end else begin
			run.push_back('{c, 1'b0});
		end
		run[run.size()-1].last = 1'b1;
		if (is_nl) begin
			if (!(cfg_sh.number_nonempty && empty)) count_advance();
			line_start = 1'b1;
		end
		prev_empty = empty;
		if (keep)
			foreach (run[k]) exp_chars.push_back(run[k]);
	endfunction

	function automatic logic [7:0] pick_byte();
		int sel;
		sel = $urandom_range(99);
		if (sel < 25) return CH_NL;
		if (sel < 35) return CH_TAB;
		if (sel < 45) return 8'($urandom_range(31));
		if (sel < 75) return 8'($urandom_range(126, 32));
		if (sel < 90) return 8'($urandom_range(255, 127));
		return 8'($urandom_range(255));
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit fixed, input logic [7:0] want);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_if.valid = 1'b0;
			@(negedge clk);
		end
		in_if.valid = 1'b1;
		in_if.in_byte = b;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		n_items++;
		predict_text(b, !fixed);
		if (fixed) exp_chars.push_back('{want, 1'b1});
	endtask

	// hold the sender until every queued character has come out
	task automatic wait_drained();
		@(negedge clk);
		in_if.valid = 1'b0;
		while (exp_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		n_writes++;
		case (idx)
			REG_NUMBER_ALL:      cfg_sh.number_all = val;
			REG_NUMBER_NONEMPTY: cfg_sh.number_nonempty = val;
			REG_FOLD_EMPTY:      cfg_sh.fold_empty = val;
			REG_MARK_TABS:       cfg_sh.mark_tabs = val;
			REG_MARK_ENDS:       cfg_sh.mark_ends = val;
			REG_SHOW_CONTROL:    cfg_sh.show_control = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic write_all(input tlnf_cfg_t v);
		wait_drained();
		write_reg(REG_NUMBER_ALL, v.number_all);
		write_reg(REG_NUMBER_NONEMPTY, v.number_nonempty);
		write_reg(REG_FOLD_EMPTY, v.fold_empty);
		write_reg(REG_MARK_TABS, v.mark_tabs);
		write_reg(REG_MARK_ENDS, v.mark_ends);
		write_reg(REG_SHOW_CONTROL, v.show_control);
	endtask

	always @(negedge clk)
		out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			n_chars++;
			if (exp_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected char %h last %b", out_if.out_byte, out_if.last_of_run);
			end else if (out_if.out_byte !== exp_chars[0].ch
					|| out_if.last_of_run !== exp_chars[0].last) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("char mismatch: expected %h last %b, got %h last %b",
						exp_chars[0].ch, exp_chars[0].last,
						out_if.out_byte, out_if.last_of_run);
				void'(exp_chars.pop_front());
			end else begin
				void'(exp_chars.pop_front());
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		in_if.valid = 1'b0;
		in_if.in_byte = 8'h00;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_NUMBER_ALL;
		cfg_if.data = 1'b0;
		out_if.ready = 1'b0;
		cfg_sh = '0;
		line_cnt = COUNT_W'(1);
		line_start = 1'b1;
		prev_empty = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_plan[r]) begin
			if (dir_plan[r].is_cfg) begin
				wait_drained();
				write_reg(dir_plan[r].idx, dir_plan[r].val);
			end else begin
				send_byte(dir_plan[r].b, dir_plan[r].fixed, dir_plan[r].want);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 0)
				write_all('1);
			else if (p == 1)
				write_all('0);
			else
				write_all(tlnf_cfg_t'(6'($urandom_range(63))));
			no_idle = (p == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2) wait_drained();
				send_byte(pick_byte(), 1'b0, 8'h00);
			end
		end
		no_idle = 1'b0;

		// numbered lines with visible ends to close the run
		write_all('{number_all: 1'b1, mark_ends: 1'b1, default: 1'b0});
		repeat (3) begin
			send_byte(8'h78, 1'b0, 8'h00);
			send_byte(CH_NL, 1'b0, 8'h00);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d bytes in, %0d chars out, %0d register writes, %0d mismatches",
			n_items, n_chars, n_writes, mismatches);
		$display("directed table, %0d random phases of %0d bytes, last line number %0h",
			N_PHASES, PHASE_ITEMS, line_cnt);
		if (mismatches == 0 && exp_chars.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

[files.f]
+incdir+hdl
hdl/tlnf_pkg.sv
hdl/tlnf_ifs.sv
hdl/tlnf_front.sv
hdl/tlnf_queue.sv
hdl/tlnf_back.sv
hdl/text_line_number_filter.sv
hdl/tlnf_checker.sv
tb/sv/tb.sv
